>>> hdl/per_client_token_bucket_policer_core_defines.svh
// ----------------------------------------------------------------------------
// Policer assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PER_CLIENT_TOKEN_BUCKET_POLICER_CORE_DEFINES_SVH
`define PER_CLIENT_TOKEN_BUCKET_POLICER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define PCTBP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pctbp assertion failed");
// Next-cycle implication
`define PCTBP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pctbp assertion failed");
`else
`define PCTBP_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define PCTBP_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

>>> hdl/pctbp_pkg.sv
// ----------------------------------------------------------------------------
// Policer package
// Shared types and constants of the per-client token bucket policer.
// ----------------------------------------------------------------------------
`default_nettype none
package pctbp_pkg;

  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;
  localparam logic [35:0] ONE_TOKEN  = 36'd1000000;
  localparam logic [19:0] TOKEN_SCALE = 20'd1000000;
  localparam logic [7:0]  VIOL_MAX   = 8'd255;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_RATE  = 2'd0,
    REG_BURST = 2'd1,
    REG_IDLE  = 2'd2,
    REG_THR   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [19:0] rate;
    logic [15:0] burst;
    logic [31:0] idle;
    logic [7:0]  thr;
  } cfg_t;

  // One bucket of a set
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [35:0] tokens;
    logic [47:0] last_ms;
    logic [7:0]  viol;
  } way_t;

endpackage
`default_nettype wire

>>> hdl/pctbp_if.sv
// ----------------------------------------------------------------------------
// Policer channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface pctbp_req_if;
  logic        valid;
  logic        ready;
  logic        has_address;
  logic [31:0] client_addr;
  logic [47:0] time_ms;
  modport source (output valid, has_address, client_addr, time_ms, input ready);
  modport sink   (input valid, has_address, client_addr, time_ms, output ready);
endinterface

interface pctbp_res_if;
  logic valid;
  logic ready;
  logic allowed;
  logic block_request;
  logic untracked;
  modport source (output valid, allowed, block_request, untracked, input ready);
  modport sink   (input valid, allowed, block_request, untracked, output ready);
endinterface
`default_nettype wire

>>> hdl/per_client_token_bucket_policer_core.sv
// ----------------------------------------------------------------------------
// Per-client token bucket policer
// Hashes the client address to a set, reads the set, frees idle ways,
// refills and spends the bucket, and writes the set back.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake      Payload
// in_req    in         valid/ready    has_address, client_addr, time_ms
// out_res   out        valid/ready    allowed, block_request, untracked
// cfg       in         psel/penable   4 registers, 32-bit data
//
// A tracked request passes from accept to result through the iterative
// hash, a memory read, the lookup, the split refill multiply (ST_MUL0, then
// ST_MUL1) and the write-back; a request without address skips to the result.
// After reset a clearing pass writes every set once, with in_req.ready low.
// The output register holds a result while out_res stalls, and the next
// request is accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_client_token_bucket_policer_core_defines.svh"
module per_client_token_bucket_policer_core #(
  parameter int SETS = 1024,
  parameter int WAYS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pctbp_req_if.sink        in_req,
  pctbp_res_if.source      out_res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W = WAYS * $bits(pctbp_pkg::way_t);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_HASH  = 8'b0000_0100,
    ST_RD    = 8'b0000_1000,
    ST_EVAL  = 8'b0001_0000,
    ST_MUL0  = 8'b0010_0000,
    ST_MUL1  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  typedef pctbp_pkg::way_t [WAYS-1:0] row_t;

  state_t          state_r, state_nxt;
  pctbp_pkg::cfg_t cfg;
  logic [SET_W-1:0] clr_r;
  logic [SET_W-1:0] set_r;
  logic [31:0]     addr_r;
  logic [47:0]     now_r;
  logic [35:0]     cap_r;
  logic            noaddr_r;
  logic            untracked_r;
  logic [WAY_W-1:0] hit_r;
  row_t            row_r;
  pctbp_pkg::way_t way_r;
  logic [47:0]     el_r;
  logic [37:0]     p_lo_r, p_hi_r;
  logic            out_valid_r, out_allowed_r, out_block_r, out_untracked_r;

  logic            accept;
  logic            fin_go;
  logic            hash_done;
  logic [31:0]     hash;
  logic            mem_we;
  logic [SET_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata, mem_rdata;
  row_t            row_rd, row_eval, row_fin;
  pctbp_pkg::way_t way_sel, way_fin;
  logic            found, have_free;
  logic [WAY_W-1:0] hit_idx, free_idx;
  logic [47:0]     el_sel;
  logic [56:0]     prod, sum, cap57;
  logic [35:0]     t_ref;
  logic [7:0]      viol_inc;
  logic            allow, block;
  logic            res_allowed, res_block, res_untracked;

  // Registers
  pctbp_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Address hash
  pctbp_hash u_hash (
    .clk, .rst_n,
    .start (accept && in_req.has_address),
    .addr  (in_req.client_addr),
    .done  (hash_done),
    .hash  (hash)
  );

  // Bucket memory, one set per row
  pctbp_mem #(.DEPTH(SETS), .WIDTH(ROW_W)) u_mem (
    .clk,
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (state_r == ST_RD),
    .raddr (set_r),
    .rdata (mem_rdata)
  );

  assign accept  = in_req.valid && in_req.ready;
  assign fin_go  = !out_valid_r || out_res.ready;
  assign in_req.ready = (state_r == ST_IDLE);

  assign mem_we    = (state_r == ST_CLEAR) ||
                     (state_r == ST_FIN && fin_go && !noaddr_r);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_r : set_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : ROW_W'(row_fin);
  assign row_rd    = row_t'(mem_rdata);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == SET_W'(SETS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = in_req.has_address ? ST_HASH : ST_FIN;
      ST_HASH:  if (hash_done) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = ST_MUL0;
      ST_MUL0:  state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + SET_W'(1);
    end
  end

  // Capture request
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r   <= in_req.client_addr;
      now_r    <= in_req.time_ms;
      noaddr_r <= !in_req.has_address;
      cap_r    <= 36'(cfg.burst) * 36'(pctbp_pkg::TOKEN_SCALE);
    end
    if (state_r == ST_HASH && hash_done) set_r <= hash[SET_W-1:0];
  end

  // Lookup: match, idle eviction, lowest free way
  always_comb begin
    row_eval  = row_rd;
    found     = 1'b0;
    have_free = 1'b0;
    hit_idx   = '0;
    free_idx  = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (row_rd[i].valid) begin
        if (row_rd[i].key == addr_r) begin
          found   = 1'b1;
          hit_idx = WAY_W'(i);
        end else if ((now_r - row_rd[i].last_ms) > {16'd0, cfg.idle}) begin
          row_eval[i].valid = 1'b0;
        end
      end
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!row_eval[i].valid) begin
        have_free = 1'b1;
        free_idx  = WAY_W'(i);
      end
    end
    if (found) begin
      way_sel = row_eval[hit_idx];
      el_sel  = now_r - way_sel.last_ms;
    end else begin
      way_sel.valid   = 1'b1;
      way_sel.key     = addr_r;
      way_sel.tokens  = cap_r;
      way_sel.last_ms = now_r;
      way_sel.viol    = 8'd0;
      el_sel          = 48'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EVAL) begin
      row_r       <= row_eval;
      way_r       <= way_sel;
      el_r        <= el_sel;
      hit_r       <= found ? hit_idx : free_idx;
      untracked_r <= !found && !have_free;
    end
    if (state_r == ST_MUL0) p_lo_r <= cfg.rate * el_r[17:0];
    if (state_r == ST_MUL1) p_hi_r <= cfg.rate * el_r[35:18];
  end

  // Refill, clamp, spend
  always_comb begin
    prod  = {1'b0, p_hi_r, 18'd0} + {19'd0, p_lo_r};
    sum   = {21'd0, way_r.tokens} + prod;
    cap57 = {21'd0, cap_r};
    if (el_r == 48'd0) begin
      t_ref = way_r.tokens;
    end else if ((|el_r[47:36]) && (cfg.rate != 20'd0)) begin
      t_ref = cap_r;
    end else if (sum > cap57) begin
      t_ref = cap_r;
    end else begin
      t_ref = sum[35:0];
    end
    allow    = (t_ref >= pctbp_pkg::ONE_TOKEN);
    viol_inc = (way_r.viol == pctbp_pkg::VIOL_MAX) ? way_r.viol : way_r.viol + 8'd1;
    block    = (viol_inc >= cfg.thr);
    way_fin         = way_r;
    way_fin.tokens  = allow ? t_ref - pctbp_pkg::ONE_TOKEN : t_ref;
    way_fin.last_ms = (el_r == 48'd0) ? way_r.last_ms : now_r;
    way_fin.viol    = allow ? way_r.viol : viol_inc;
    row_fin = row_r;
    if (!untracked_r) row_fin[hit_r] = way_fin;
    if (noaddr_r) begin
      res_allowed = 1'b1; res_block = 1'b0; res_untracked = 1'b0;
    end else if (untracked_r) begin
      res_allowed = 1'b1; res_block = 1'b0; res_untracked = 1'b1;
    end else begin
      res_allowed = allow; res_block = !allow && block; res_untracked = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && fin_go) begin
      out_allowed_r   <= res_allowed;
      out_block_r     <= res_block;
      out_untracked_r <= res_untracked;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.allowed       = out_allowed_r;
  assign out_res.block_request = out_block_r;
  assign out_res.untracked     = out_untracked_r;

  `PCTBP_ASSERT_IMP(a_clear_blocks_req, clk, rst_n, state_r == ST_CLEAR, !in_req.ready)
  `PCTBP_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, accept, state_r != ST_IDLE)
  `PCTBP_ASSERT_IMP(a_write_phase, clk, rst_n, mem_we, state_r == ST_CLEAR || state_r == ST_FIN)
  `PCTBP_ASSERT_NXT(a_fin_loads_out, clk, rst_n, state_r == ST_FIN && fin_go, out_valid_r)

endmodule
`default_nettype wire

>>> hdl/pctbp_cfg.sv
// ----------------------------------------------------------------------------
// Policer register file
// APB-style registers for rate, burst, idle timeout and block threshold.
// ----------------------------------------------------------------------------
`default_nettype none
module pctbp_cfg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output pctbp_pkg::cfg_t          cfg
);

  pctbp_pkg::cfg_t    cfg_r;
  pctbp_pkg::reg_idx_t idx;

  assign idx    = pctbp_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate  <= 20'd2000;
      cfg_r.burst <= 16'd20;
      cfg_r.idle  <= 32'd600000;
      cfg_r.thr   <= 8'd5;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        pctbp_pkg::REG_RATE:  cfg_r.rate  <= pwdata[19:0];
        pctbp_pkg::REG_BURST: cfg_r.burst <= pwdata[15:0];
        pctbp_pkg::REG_IDLE:  cfg_r.idle  <= pwdata;
        pctbp_pkg::REG_THR:   cfg_r.thr   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      pctbp_pkg::REG_RATE:  prdata = {12'd0, cfg_r.rate};
      pctbp_pkg::REG_BURST: prdata = {16'd0, cfg_r.burst};
      pctbp_pkg::REG_IDLE:  prdata = cfg_r.idle;
      pctbp_pkg::REG_THR:   prdata = {24'd0, cfg_r.thr};
      default:              prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/pctbp_hash.sv
// ----------------------------------------------------------------------------
// Policer address hash
// Iterative FNV-1a over four address bytes, one multiply per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pctbp_hash (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] addr,
  output logic             done,
  output logic [31:0]      hash
);

  logic [31:0] h_r, h_nxt;
  logic [31:0] addr_r;
  logic [1:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [7:0]  byte_sel;
  logic [31:0] mixed;

  // Most significant byte first
  assign byte_sel = addr_r[31:24];
  assign mixed    = h_r ^ {24'd0, byte_sel};
  assign h_nxt    = mixed * pctbp_pkg::HASH_PRIME;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift out one byte per step
  always_ff @(posedge clk) begin
    if (start) begin
      h_r    <= pctbp_pkg::HASH_BASIS;
      addr_r <= addr;
    end else if (busy_r) begin
      h_r    <= h_nxt;
      addr_r <= {addr_r[23:0], 8'd0};
    end
  end

  assign done = done_r;
  assign hash = h_r;

endmodule
`default_nettype wire

>>> hdl/pctbp_mem.sv
// ----------------------------------------------------------------------------
// Policer bucket memory
// One-write, one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module pctbp_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 500
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> dv/per_client_token_bucket_policer_core_tb.sv
// ----------------------------------------------------------------------------
// Policer core testbench
// Drives client requests and register writes into the token bucket policer,
// predicts each verdict with a local bucket table and compares the results.
// ----------------------------------------------------------------------------
`default_nettype none
module per_client_token_bucket_policer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NSETS     = 1024;
  localparam int          NWAYS     = 4;
  localparam int          NENT      = NSETS * NWAYS;
  localparam int          DRAIN_CYC = 24;
  localparam int          MAX_CYC   = 600000;
  localparam logic [63:0] TOKEN     = 64'd1000000;

  typedef struct packed {
    logic allowed;
    logic block_request;
    logic untracked;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pctbp_req_if in_req ();
  pctbp_res_if out_res ();

  per_client_token_bucket_policer_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req.sink),
    .out_res (out_res.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Local copy of the configuration and the bucket table
  logic [19:0] cur_rate = 20'd2000;
  logic [15:0] cur_burst = 16'd20;
  logic [31:0] cur_idle = 32'd600000;
  logic [7:0]  cur_thr = 8'd5;
  bit          bk_valid [NENT];
  logic [31:0] bk_key   [NENT];
  logic [63:0] bk_tok   [NENT];
  logic [47:0] bk_last  [NENT];
  logic [7:0]  bk_viol  [NENT];

  verdict_t    pending_verdicts[$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_deny = 0;
  int          n_block = 0;
  int          n_untracked = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  logic [47:0] now_ms = '0;
  logic [31:0] pool[$];
  logic [31:0] crowd[$];

  function automatic logic [9:0] set_of(logic [31:0] addr);
    logic [31:0] h;
    h = pctbp_pkg::HASH_BASIS;
    for (int b = 3; b >= 0; b--) begin
      h = (h ^ {24'd0, addr[8*b +: 8]}) * pctbp_pkg::HASH_PRIME;
    end
    return h[9:0];
  endfunction

  // Compute the verdict and update the bucket table for one request
  function automatic verdict_t police(logic has_addr, logic [31:0] addr, logic [47:0] t);
    verdict_t    v;
    int          base;
    int          hit;
    bit          found;
    logic [47:0] el;
    logic [63:0] cap;
    logic [63:0] tk;
    v = '{allowed: 1'b1, block_request: 1'b0, untracked: 1'b0};
    if (!has_addr) return v;
    base = int'(set_of(addr)) * NWAYS;
    found = 1'b0;
    hit = -1;
    for (int i = 0; i < NWAYS; i++) begin
      if (bk_valid[base+i]) begin
        if (bk_key[base+i] == addr) begin
          found = 1'b1;
          hit = base + i;
        end else if ((t - bk_last[base+i]) > {16'd0, cur_idle}) begin
          bk_valid[base+i] = 1'b0;
        end
      end
    end
    cap = 64'(cur_burst) * TOKEN;
    if (!found) begin
      for (int i = NWAYS - 1; i >= 0; i--) if (!bk_valid[base+i]) hit = base + i;
      if (hit < 0) begin
        v.untracked = 1'b1;
        return v;
      end
      bk_valid[hit] = 1'b1;
      bk_key[hit] = addr;
      bk_tok[hit] = cap;
      bk_last[hit] = t;
      bk_viol[hit] = '0;
    end
    // Refill, only when time has moved
    el = t - bk_last[hit];
    if (el != 0) begin
      tk = bk_tok[hit];
      if (cur_rate != 0) begin
        if (64'(el) > cap / 64'(cur_rate)) tk = cap;
        else tk = tk + 64'(cur_rate) * 64'(el);
      end
      if (tk > cap) tk = cap;
      bk_tok[hit] = tk;
      bk_last[hit] = t;
    end
    if (bk_tok[hit] >= TOKEN) begin
      bk_tok[hit] = bk_tok[hit] - TOKEN;
      return v;
    end
    if (bk_viol[hit] != pctbp_pkg::VIOL_MAX) bk_viol[hit] = bk_viol[hit] + 8'd1;
    v.allowed = 1'b0;
    v.block_request = (bk_viol[hit] >= cur_thr);
    return v;
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    $display("tb: mismatch on result %0d: %s got %0b want %0b", n_checked, what, got, want);
    errors++;
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stalls, drive at falling edge
  initial out_res.ready = 1'b0;
  always @(negedge clk) out_res.ready <= calm || ($urandom_range(99) >= 17);

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("valid", 1'b1, 1'b0);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_res.allowed !== want.allowed)
          report_mismatch("allowed", out_res.allowed, want.allowed);
        if (out_res.block_request !== want.block_request)
          report_mismatch("block_request", out_res.block_request, want.block_request);
        if (out_res.untracked !== want.untracked)
          report_mismatch("untracked", out_res.untracked, want.untracked);
      end
      n_checked++;
    end
  end

  // Send one request; predict on acceptance
  task automatic send_req(logic has_addr, logic [31:0] addr, logic [47:0] t);
    verdict_t v;
    while (!calm && $urandom_range(99) < 17) begin
      @(negedge clk);
      in_req.valid <= 1'b0;
    end
    @(negedge clk);
    in_req.valid <= 1'b1;
    in_req.has_address <= has_addr;
    in_req.client_addr <= addr;
    in_req.time_ms <= t;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    v = police(has_addr, addr, t);
    pending_verdicts.push_back(v);
    n_sent++;
    if (!v.allowed) n_deny++;
    if (v.block_request) n_block++;
    if (v.untracked) n_untracked++;
    // Drop valid after the accepting edge
    @(negedge clk);
    in_req.valid <= 1'b0;
  endtask

  // Hold until every expected result is in, then let the pipe empty
  task automatic wait_drained();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(pctbp_pkg::reg_idx_t idx, logic [31:0] val);
    wait_drained();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      pctbp_pkg::REG_RATE:  cur_rate = val[19:0];
      pctbp_pkg::REG_BURST: cur_burst = val[15:0];
      pctbp_pkg::REG_IDLE:  cur_idle = val;
      pctbp_pkg::REG_THR:   cur_thr = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_cfg(logic [31:0] r, logic [31:0] b, logic [31:0] i, logic [31:0] th);
    write_reg(pctbp_pkg::REG_RATE, r);
    write_reg(pctbp_pkg::REG_BURST, b);
    write_reg(pctbp_pkg::REG_IDLE, i);
    write_reg(pctbp_pkg::REG_THR, th);
  endtask

  // Find addresses that share one set, enough to overflow it
  task automatic build_pools();
    logic [31:0] a;
    logic [9:0]  s;
    s = set_of(32'hC0A8_0001);
    crowd.push_back(32'hC0A8_0001);
    a = 32'h0A00_0000;
    while (crowd.size() < NWAYS + 2) begin
      if (set_of(a) == s) crowd.push_back(a);
      a = a + 32'd1;
    end
    for (int k = 0; k < 18; k++) pool.push_back($urandom());
    foreach (crowd[k]) pool.push_back(crowd[k]);
  endtask

  task automatic test_no_address();
    send_req(1'b0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_req(1'b0, 32'h0000_0000, 48'd0);
  endtask

  // Small bucket drained at one instant; deny and block at threshold
  task automatic test_drain_and_block();
    set_cfg(32'd0, 32'd2, 32'hFFFF_FFFF, 32'd2);
    for (int k = 0; k < 5; k++) send_req(1'b1, 32'h0000_0000, 48'd1000);
    write_reg(pctbp_pkg::REG_THR, 32'd0);
    send_req(1'b1, 32'h0000_0000, 48'd1001);
    write_reg(pctbp_pkg::REG_THR, 32'd255);
    send_req(1'b1, 32'h0000_0000, 48'd1002);
  endtask

  // Zero burst, lowered burst, a one-token-per-ms refill and a slow refill
  task automatic test_burst_and_rate();
    set_cfg(32'd1000000, 32'd0, 32'hFFFF_FFFF, 32'd1);
    send_req(1'b1, 32'hFFFF_FFFF, 48'd5);
    set_cfg(32'd1000000, 32'd65535, 32'hFFFF_FFFF, 32'd1);
    send_req(1'b1, 32'h1234_5678, 48'd10);
    write_reg(pctbp_pkg::REG_BURST, 32'd1);
    send_req(1'b1, 32'h1234_5678, 48'd11);
    send_req(1'b1, 32'h1234_5678, 48'd11);
    write_reg(pctbp_pkg::REG_RATE, 32'd1);
    send_req(1'b1, 32'h1234_5678, 48'd12);
  endtask

  // Time wrapping past the 48-bit maximum reads as a short elapsed time
  task automatic test_time_wrap();
    send_req(1'b1, 32'h1234_5678, 48'hFFFF_FFFF_FFFF);
    send_req(1'b1, 32'h1234_5678, 48'd3);
  endtask

  // Fill one set, overflow it, then free it by idle time
  task automatic test_crowd_and_evict();
    set_cfg(32'd2000, 32'd20, 32'd100, 32'd5);
    for (int k = 0; k <= NWAYS; k++) send_req(1'b1, crowd[k], 48'd50000);
    send_req(1'b1, crowd[NWAYS+1], 48'd50100);
    send_req(1'b1, crowd[NWAYS+1], 48'd50101);
    write_reg(pctbp_pkg::REG_IDLE, 32'd0);
    send_req(1'b1, crowd[0], 48'd50102);
  endtask

  task automatic test_random(int n_items);
    logic [31:0] a;
    logic [47:0] t;
    int          step_max;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_cfg(32'd2000, 32'd20, 32'd600000, 32'd5);
        1: set_cfg(32'd300, 32'd2, 32'd5000, 32'd3);
        2: set_cfg(32'd1000000, 32'd65535, 32'hFFFF_FFFF, 32'd255);
        3: set_cfg(32'd0, 32'd1, 32'd0, 32'd0);
        4: set_cfg($urandom_range(1, 3000), $urandom_range(1, 4),
                   $urandom_range(10, 3000), $urandom_range(1, 8));
        default: set_cfg($urandom_range(1000000), $urandom_range(65535),
                         $urandom(), $urandom_range(255));
      endcase
      calm = (ph == 2);
      step_max = (ph == 2) ? 2000 : 400;
      for (int k = 0; k < n_items / 6; k++) begin
        if (ph == 4 && k == 40) wait_drained();
        case ($urandom_range(19))
          0: a = $urandom();
          1, 2, 3: a = crowd[$urandom_range(crowd.size() - 1)];
          default: a = pool[$urandom_range(pool.size() - 1)];
        endcase
        if ($urandom_range(49) == 0) now_ms = {$urandom(), 16'($urandom())};
        else now_ms = now_ms + 48'($urandom_range(step_max));
        t = now_ms;
        send_req($urandom_range(9) != 0, a, t);
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    in_req.valid = 1'b0;
    in_req.has_address = 1'b0;
    in_req.client_addr = '0;
    in_req.time_ms = '0;
    build_pools();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_no_address();
    test_drain_and_block();
    test_burst_and_rate();
    test_time_wrap();
    test_crowd_and_evict();
    test_random(1050);
    wait_drained();
    $display("tb: %0d requests sent, %0d results checked", n_sent, n_checked);
    $display("tb: %0d denied, %0d block requests, %0d untracked, over six settings",
             n_deny, n_block, n_untracked);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> per_client_token_bucket_policer_core.f
+incdir+hdl
hdl/pctbp_pkg.sv
hdl/pctbp_if.sv
hdl/pctbp_cfg.sv
hdl/pctbp_hash.sv
hdl/pctbp_mem.sv
hdl/per_client_token_bucket_policer_core.sv
dv/per_client_token_bucket_policer_core_tb.sv
